[hw/rtl/dtci_pkg.sv]
// Shared constants and types for the clamped decimal text converter.
`timescale 1ns / 1ps
`default_nettype none

package dtci_pkg;

    // Default width of the converted value and of each configuration register.
    localparam int VALUE_WIDTH_DEF = 32;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_VALUE     = 2'd0,
        CFG_MAX_VALUE     = 2'd1,
        CFG_DEFAULT_VALUE = 2'd2
    } t_cfg_idx;

    // Character codes that the parser recognizes.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

endpackage : dtci_pkg

`default_nettype wire

[hw/rtl/decimal_text_to_clamped_int.sv]
// Top level of the clamped decimal text to integer converter.
//
// Usage: text arrives one byte per request on the input channel (i_in_valid,
// i_text_byte, o_in_stall). A field ends with a NUL byte; an optional leading
// minus sets the sign. On the NUL byte one result request goes out on the
// output channel (o_out_valid, o_parsed_value, o_bad_field, i_out_stall).
// Other bytes produce no result.
// The result of a NUL byte accepted at a clock edge is valid after that edge.
// Throughput is one byte per cycle while o_in_stall is low: parser state
// updates in a single pass through a shift-add times-ten and two compares.
// The output register is the only buffer; the input stalls only while a
// result is held and the receiver stalls, and a byte is accepted in the same
// cycle that a held result is taken.
// Bounds and default are written through i_cfg_we / i_cfg_idx / i_cfg_data.
// Synchronous reset restores the bounds to the full signed range, the
// default to zero, rearms the parser and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_clamped_int #(
    parameter int VALUE_WIDTH = dtci_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [dtci_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [VALUE_WIDTH-1:0]            i_cfg_data,
    // Input text channel.
    input  wire logic                              i_in_valid,
    input  wire logic [7:0]                        i_text_byte,
    output logic                                   o_in_stall,
    // Output result channel.
    output logic                                   o_out_valid,
    output logic signed [VALUE_WIDTH-1:0]          o_parsed_value,
    output logic                                   o_bad_field,
    input  wire logic                              i_out_stall
);

    // Running value carries four extra bits so that times ten plus a digit
    // cannot overflow before the bound check.
    localparam int RW = VALUE_WIDTH + 4;

    // Configuration registers.
    logic signed [VALUE_WIDTH-1:0] r_min_value;
    logic signed [VALUE_WIDTH-1:0] r_max_value;
    logic signed [VALUE_WIDTH-1:0] r_default_value;

    // Parser state.
    logic                          r_at_start, n_at_start;
    logic                          r_neg, n_neg;
    logic                          r_seen, n_seen;
    logic                          r_decided, n_decided;
    logic signed [RW-1:0]          r_run, n_run;
    logic signed [VALUE_WIDTH-1:0] r_held_val, n_held_val;
    logic                          r_held_err, n_held_err;

    // Output register.
    logic                          r_out_valid, n_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_out_value, n_out_value;
    logic                          r_out_err, n_out_err;

    logic                          w_in_acc;
    logic                          w_is_nul;
    logic                          w_is_digit;
    logic signed [RW-1:0]          w_digit;
    logic signed [RW-1:0]          w_times10;
    logic signed [RW-1:0]          w_next_run;
    logic signed [RW-1:0]          w_lo;
    logic signed [RW-1:0]          w_hi;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_value     <= {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            r_max_value     <= {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            r_default_value <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dtci_pkg::CFG_MIN_VALUE:     r_min_value     <= i_cfg_data;
                dtci_pkg::CFG_MAX_VALUE:     r_max_value     <= i_cfg_data;
                dtci_pkg::CFG_DEFAULT_VALUE: r_default_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: a byte is taken whenever the output register is free or
    // being emptied in this cycle.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    // Byte classification and the digit update.
    assign w_is_nul   = (i_text_byte == dtci_pkg::CHAR_NUL);
    assign w_is_digit = (i_text_byte >= dtci_pkg::CHAR_ZERO) &&
                        (i_text_byte <= dtci_pkg::CHAR_NINE);
    assign w_digit    = $signed({{(RW-4){1'b0}}, i_text_byte[3:0]});
    assign w_times10  = (r_run <<< 3) + (r_run <<< 1);
    assign w_next_run = r_neg ? (w_times10 - w_digit) : (w_times10 + w_digit);
    assign w_lo       = $signed({{4{r_min_value[VALUE_WIDTH-1]}}, r_min_value});
    assign w_hi       = $signed({{4{r_max_value[VALUE_WIDTH-1]}}, r_max_value});

    // Next state of the parser and the output register.
    always_comb begin
        n_at_start  = r_at_start;
        n_neg       = r_neg;
        n_seen      = r_seen;
        n_decided   = r_decided;
        n_run       = r_run;
        n_held_val  = r_held_val;
        n_held_err  = r_held_err;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_value = r_out_value;
        n_out_err   = r_out_err;

        if (w_in_acc) begin
            if (w_is_nul) begin
                // End of field: emit the result and rearm.
                n_out_valid = 1'b1;
                if (r_decided) begin
                    n_out_value = r_held_val;
                    n_out_err   = r_held_err;
                end else if (!r_seen) begin
                    n_out_value = r_default_value;
                    n_out_err   = 1'b1;
                end else begin
                    n_out_value = r_run[VALUE_WIDTH-1:0];
                    n_out_err   = 1'b0;
                end
                n_at_start = 1'b1;
                n_neg      = 1'b0;
                n_seen     = 1'b0;
                n_decided  = 1'b0;
                n_run      = '0;
                n_held_val = '0;
                n_held_err = 1'b0;
            end else begin
                n_at_start = 1'b0;
                if (!r_decided) begin
                    if (r_at_start && (i_text_byte == dtci_pkg::CHAR_MINUS)) begin
                        n_neg = 1'b1;
                    end else if (!w_is_digit) begin
                        n_decided  = 1'b1;
                        n_held_val = r_default_value;
                        n_held_err = 1'b1;
                    end else begin
                        // The lower bound is checked first, so it wins
                        // when the bounds are crossed.
                        n_run  = w_next_run;
                        n_seen = 1'b1;
                        if (w_next_run < w_lo) begin
                            n_decided  = 1'b1;
                            n_held_val = r_min_value;
                            n_held_err = 1'b1;
                        end else if (w_next_run > w_hi) begin
                            n_decided  = 1'b1;
                            n_held_val = r_max_value;
                            n_held_err = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_neg      <= 1'b0;
            r_seen     <= 1'b0;
            r_decided  <= 1'b0;
            r_run      <= '0;
            r_held_val <= '0;
            r_held_err <= 1'b0;
        end else begin
            r_at_start <= n_at_start;
            r_neg      <= n_neg;
            r_seen     <= n_seen;
            r_decided  <= n_decided;
            r_run      <= n_run;
            r_held_val <= n_held_val;
            r_held_err <= n_held_err;
        end
    end

    // Output register; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_value <= n_out_value;
        r_out_err   <= n_out_err;
    end

    assign o_out_valid    = r_out_valid;
    assign o_parsed_value = r_out_value;
    assign o_bad_field    = r_out_err;

endmodule : decimal_text_to_clamped_int

`default_nettype wire

[hw/rtl/dtci_checker.sv]
// Port-level checks for the clamped decimal text converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dtci_checker #(
    parameter int VALUE_WIDTH = dtci_pkg::VALUE_WIDTH_DEF
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic [7:0]                     i_text_byte,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic [VALUE_WIDTH-1:0]         o_parsed_value,
    input wire logic                           o_bad_field,
    input wire logic                           i_out_stall
);

    logic w_in_acc;
    logic w_nul_acc;

    assign w_in_acc  = i_in_valid & ~o_in_stall;
    assign w_nul_acc = w_in_acc && (i_text_byte == dtci_pkg::CHAR_NUL);

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result still valid after reset");

    // A held result stays put while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_parsed_value) && $stable(o_bad_field))
        else $error("stalled result changed");

    // The input stalls only while a result is held back by the receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // Every accepted end of field yields a result in the next cycle.
    a_nul_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_nul_acc |=> o_out_valid)
        else $error("end of field produced no result");

    // A fresh result appears only after an end of field was accepted.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !($past(o_out_valid) && $past(i_out_stall)) |->
            $past(w_nul_acc))
        else $error("result without an end of field");

endmodule : dtci_checker

bind decimal_text_to_clamped_int dtci_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_dtci_checker (.*);

`default_nettype wire
